// ===== rtl/window_median_filter_macros.svh =====
// Assertion helpers for the window median filter.
// Each macro expects clk_i and rst_ni in scope.
`ifndef WINDOW_MEDIAN_FILTER_MACROS_SVH
`define WINDOW_MEDIAN_FILTER_MACROS_SVH

// The condition must never hold at a clock edge.
`define WMF_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("window_median_filter: assertion failed");

// Whenever ante holds, cons holds in the same cycle.
`define WMF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("window_median_filter: assertion failed");

`endif

// ===== rtl/wmf_pkg.sv =====
package wmf_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_RADIUS = 3;
  localparam int unsigned MAX_HEIGHT = 4096;

  localparam int unsigned NSLOT  = 2 * MAX_RADIUS + 1;
  localparam int unsigned WIN_N  = NSLOT * NSLOT;
  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned EW_W   = COL_W + 1;
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT) + 1;
  localparam int unsigned SLOT_W = $clog2(NSLOT);
  localparam int unsigned KW     = $clog2(NSLOT + 1);
  localparam int unsigned RAD_W  = 2;
  localparam int unsigned WREG_W = 11;
  localparam int unsigned HREG_W = 13;
  localparam int unsigned PIX_W  = 24;
  localparam int unsigned CNT_W  = 3;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  typedef enum logic [0:0] {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2,
    REG_COLOR  = 2'd3
  } reg_e;

  typedef struct packed {
    op_e        operation;
    logic [7:0] chan_a;
    logic [7:0] chan_b;
    logic [7:0] chan_c;
  } in_item_t;

  typedef struct packed {
    logic [7:0] med_a;
    logic [7:0] med_b;
    logic [7:0] med_c;
    logic       last_in_run;
    logic       frame_done;
  } out_item_t;

  // Effective (range-limited) configuration.
  typedef struct packed {
    logic [RAD_W-1:0] radius;
    logic [EW_W-1:0]  width;
    logic [ROW_W-1:0] height;
    logic             color;
  } cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [SLOT_W-1:0] slot;
  } pos_t;

  // One command from the front to the back: an optional line store write
  // followed by an optional window median.
  typedef struct packed {
    logic              has_wr;
    logic [SLOT_W-1:0] wr_slot;
    logic [COL_W-1:0]  wr_col;
    logic [PIX_W-1:0]  pix;
    logic              has_em;
    pos_t              em_pos;
    logic              last;
    logic              done;
  } cmd_t;

endpackage

// ===== rtl/wmf_queue.sv =====
module wmf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  wmf_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output wmf_pkg::cmd_t cmd_o,
  output logic          full_o,
  output logic          empty_o
);

  wmf_pkg::cmd_t                  mem_q [wmf_pkg::QDEPTH];
  logic [wmf_pkg::QPTR_W-1:0]     wr_q, rd_q;
  logic [wmf_pkg::QPTR_W:0]       cnt_q;

  assign full_o  = (cnt_q == (wmf_pkg::QPTR_W+1)'(wmf_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + wmf_pkg::QPTR_W'(1);
      if (pop_i)  rd_q <= rd_q + wmf_pkg::QPTR_W'(1);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (wmf_pkg::QPTR_W+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (wmf_pkg::QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= cmd_i;
  end

endmodule

// ===== rtl/wmf_front.sv =====
module wmf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wmf_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  wmf_pkg::in_item_t in_data_i,
  output logic              push_o,
  output wmf_pkg::cmd_t     cmd_o,
  input  logic              full_i,
  output logic              busy_o
);

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_EMIT = 2'b10
  } fstate_e;

  fstate_e                      state_q, state_d;
  logic [wmf_pkg::COL_W-1:0]    in_col_q, in_col_d;
  logic [wmf_pkg::ROW_W-1:0]    in_row_q, in_row_d;
  logic [wmf_pkg::SLOT_W-1:0]   in_slot_q, in_slot_d;
  wmf_pkg::pos_t                out_q, out_d;
  logic [wmf_pkg::ROW_W-1:0]    ir_q, ir_d;
  logic [wmf_pkg::COL_W-1:0]    ic_q, ic_d;
  logic [wmf_pkg::CNT_W-1:0]    cnt_q, cnt_d;

  logic [wmf_pkg::ROW_W-1:0]    ir;
  logic [wmf_pkg::COL_W-1:0]    ic;
  logic [wmf_pkg::SLOT_W-1:0]   islot;
  logic [wmf_pkg::EW_W-1:0]     nc;
  wmf_pkg::pos_t                op, op_n, adv_q;
  logic                         ok0, okn0, okq, drain_ok;

  function automatic logic [wmf_pkg::SLOT_W-1:0] slot_inc(
    input logic [wmf_pkg::SLOT_W-1:0] s
  );
    if (s == wmf_pkg::SLOT_W'(wmf_pkg::NSLOT - 1)) return '0;
    return s + wmf_pkg::SLOT_W'(1);
  endfunction

  function automatic wmf_pkg::pos_t adv(input wmf_pkg::pos_t p, input wmf_pkg::cfg_t c);
    wmf_pkg::pos_t          n;
    logic [wmf_pkg::EW_W-1:0] ncol;
    n    = p;
    ncol = wmf_pkg::EW_W'(p.col) + wmf_pkg::EW_W'(1);
    if (ncol >= c.width) begin
      n.col  = '0;
      n.row  = p.row + wmf_pkg::ROW_W'(1);
      n.slot = slot_inc(p.slot);
    end else begin
      n.col = ncol[wmf_pkg::COL_W-1:0];
    end
    return n;
  endfunction

  // True when the output at p may be released by the pixel at (r_in, c_in).
  function automatic logic emit_ok(
    input wmf_pkg::pos_t              p,
    input logic [wmf_pkg::CNT_W-1:0]  cnt,
    input logic [wmf_pkg::ROW_W-1:0]  r_in,
    input logic [wmf_pkg::COL_W-1:0]  c_in,
    input wmf_pkg::cfg_t              c
  );
    logic [wmf_pkg::ROW_W-1:0] rr;
    logic [wmf_pkg::EW_W:0]    need;
    logic [wmf_pkg::EW_W:0]    lim;
    rr   = wmf_pkg::ROW_W'(c.radius);
    need = (wmf_pkg::EW_W+1)'(p.col) + (wmf_pkg::EW_W+1)'(c.radius);
    lim  = (wmf_pkg::EW_W+1)'(c.width) - (wmf_pkg::EW_W+1)'(1);
    if (need > lim) need = lim;
    return (r_in >= rr) && (p.row == r_in - rr) &&
           (need <= (wmf_pkg::EW_W+1)'(c_in)) && (cnt <= wmf_pkg::CNT_W'(c.radius));
  endfunction

  assign busy_o     = (state_q == F_EMIT);
  assign in_ready_o = (state_q == F_IDLE) && !full_i;

  always_comb begin
    state_d   = state_q;
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    in_slot_d = in_slot_q;
    out_d     = out_q;
    ir_d      = ir_q;
    ic_d      = ic_q;
    cnt_d     = cnt_q;
    push_o    = 1'b0;
    cmd_o     = '0;

    // Position of this pixel: wrap a finished row, restart a finished frame.
    ir    = in_row_q;
    ic    = in_col_q;
    islot = in_slot_q;
    op    = out_q;
    if (wmf_pkg::EW_W'(in_col_q) >= cfg_i.width) begin
      ic    = '0;
      ir    = in_row_q + wmf_pkg::ROW_W'(1);
      islot = slot_inc(in_slot_q);
    end
    if (ir >= cfg_i.height) begin
      ir    = '0;
      ic    = '0;
      islot = '0;
      op    = '0;
    end
    op_n     = adv(op, cfg_i);
    ok0      = emit_ok(op, '0, ir, ic, cfg_i);
    okn0     = emit_ok(op_n, wmf_pkg::CNT_W'(1), ir, ic, cfg_i);
    nc       = wmf_pkg::EW_W'(ic) + wmf_pkg::EW_W'(1);
    adv_q    = adv(out_q, cfg_i);
    okq      = emit_ok(adv_q, cnt_q + wmf_pkg::CNT_W'(1), ir_q, ic_q, cfg_i);
    drain_ok = (in_row_q >= cfg_i.height) && (out_q.row < cfg_i.height);

    case (state_q)
      F_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          if (in_data_i.operation == wmf_pkg::OP_PIXEL) begin
            push_o        = 1'b1;
            cmd_o.has_wr  = 1'b1;
            cmd_o.wr_slot = islot;
            cmd_o.wr_col  = ic;
            cmd_o.pix     = {in_data_i.chan_c, in_data_i.chan_b, in_data_i.chan_a};
            cmd_o.has_em  = ok0;
            cmd_o.em_pos  = op;
            cmd_o.last    = !okn0;
            cmd_o.done    = (op_n.row >= cfg_i.height);
            if (nc >= cfg_i.width) begin
              in_col_d  = '0;
              in_row_d  = ir + wmf_pkg::ROW_W'(1);
              in_slot_d = slot_inc(islot);
            end else begin
              in_col_d  = nc[wmf_pkg::COL_W-1:0];
              in_row_d  = ir;
              in_slot_d = islot;
            end
            out_d = ok0 ? op_n : op;
            ir_d  = ir;
            ic_d  = ic;
            cnt_d = wmf_pkg::CNT_W'(1);
            if (ok0 && okn0) state_d = F_EMIT;
          end else if (drain_ok) begin
            push_o       = 1'b1;
            cmd_o.has_em = 1'b1;
            cmd_o.em_pos = out_q;
            cmd_o.last   = 1'b1;
            cmd_o.done   = (adv_q.row >= cfg_i.height);
            out_d        = adv_q;
          end
        end
      end
      F_EMIT: begin
        if (!full_i) begin
          push_o       = 1'b1;
          cmd_o.has_em = 1'b1;
          cmd_o.em_pos = out_q;
          cmd_o.last   = !okq;
          cmd_o.done   = (adv_q.row >= cfg_i.height);
          out_d        = adv_q;
          cnt_d        = cnt_q + wmf_pkg::CNT_W'(1);
          if (!okq) state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= F_IDLE;
      in_col_q  <= '0;
      in_row_q  <= '0;
      in_slot_q <= '0;
      out_q     <= '0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      in_slot_q <= in_slot_d;
      out_q     <= out_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ir_q <= ir_d;
    ic_q <= ic_d;
  end

endmodule

// ===== rtl/wmf_back.sv =====
module wmf_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wmf_pkg::cfg_t      cfg_i,
  input  logic               empty_i,
  input  wmf_pkg::cmd_t      cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output wmf_pkg::out_item_t out_data_o
);

  typedef enum logic [3:0] {
    B_IDLE   = 4'b0001,
    B_GATHER = 4'b0010,
    B_SELECT = 4'b0100,
    B_DONE   = 4'b1000
  } bstate_e;

  localparam int unsigned NCH   = 3;
  localparam int unsigned BIT_W = $clog2(wmf_pkg::PIX_W);
  localparam int unsigned RK_W  = $clog2(wmf_pkg::WIN_N + 1);

  bstate_e                          state_q, state_d;
  wmf_pkg::pos_t                    pos_q;
  logic                             last_q, done_q;
  logic [wmf_pkg::SLOT_W-1:0]       rslot_q [wmf_pkg::NSLOT];
  logic [wmf_pkg::KW-1:0]           k_q;
  logic                             cap_vld_q;
  logic [wmf_pkg::SLOT_W-1:0]       cap_idx_q;
  logic [wmf_pkg::NSLOT-1:0][wmf_pkg::PIX_W-1:0] rd_bus;
  logic [wmf_pkg::PIX_W-1:0]        win_q [wmf_pkg::WIN_N];
  logic [wmf_pkg::WIN_N-1:0]        cand_q [NCH];
  logic [RK_W-1:0]                  rank_q [NCH];
  logic [7:0]                       med_q [NCH];
  logic [2:0]                       bit_q;
  logic                             out_valid_q;
  wmf_pkg::out_item_t               out_q;

  logic                             wr_en, rd_en, load_out;
  logic [wmf_pkg::COL_W-1:0]        rd_col;
  logic [wmf_pkg::KW-1:0]           side;
  logic [wmf_pkg::WIN_N-1:0]        init_mask;
  logic [wmf_pkg::WIN_N-1:0]        zero_v [NCH];
  logic [wmf_pkg::WIN_N-1:0]        one_v [NCH];
  logic [RK_W-1:0]                  cnt0 [NCH];
  logic [NCH-1:0]                   pick_one;
  logic [BIT_W-1:0]                 bpos;

  function automatic logic [RK_W-1:0] med_rank(input logic [wmf_pkg::RAD_W-1:0] r);
    int n;
    n = (2 * int'(r) + 1) * (2 * int'(r) + 1);
    return RK_W'(n / 2);
  endfunction

  // Line slot feeding window row i, with rows above or below the frame
  // replaced by the first or last frame row.
  function automatic logic [wmf_pkg::SLOT_W-1:0] row_slot(
    input wmf_pkg::pos_t p, input int i, input wmf_pkg::cfg_t c
  );
    int dy;
    int top;
    int bot;
    int s;
    dy  = i - int'(c.radius);
    top = -int'(p.row);
    bot = int'(c.height) - 1 - int'(p.row);
    if (dy < top) dy = top;
    if (dy > bot) dy = bot;
    s = int'(p.slot) + dy + int'(wmf_pkg::NSLOT);
    if (s >= int'(wmf_pkg::NSLOT)) s = s - int'(wmf_pkg::NSLOT);
    if (s >= int'(wmf_pkg::NSLOT)) s = s - int'(wmf_pkg::NSLOT);
    return s[wmf_pkg::SLOT_W-1:0];
  endfunction

  function automatic logic [wmf_pkg::COL_W-1:0] win_col(
    input wmf_pkg::pos_t p, input logic [wmf_pkg::KW-1:0] k, input wmf_pkg::cfg_t c
  );
    int v;
    v = int'(p.col) + int'(k) - int'(c.radius);
    if (v < 0) v = 0;
    if (v > int'(c.width) - 1) v = int'(c.width) - 1;
    return v[wmf_pkg::COL_W-1:0];
  endfunction

  assign side        = wmf_pkg::KW'({cfg_i.radius, 1'b0});
  assign pop_o       = (state_q == B_IDLE) && !empty_i;
  assign wr_en       = pop_o && cmd_i.has_wr;
  assign rd_en       = (state_q == B_GATHER) && (k_q <= side);
  assign rd_col      = win_col(pos_q, k_q, cfg_i);
  assign load_out    = (state_q == B_DONE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  for (genvar g = 0; g < wmf_pkg::NSLOT; g++) begin : g_bank
    logic [wmf_pkg::PIX_W-1:0] mem [wmf_pkg::MAX_WIDTH];
    logic [wmf_pkg::PIX_W-1:0] rd_data;
    always_ff @(posedge clk_i) begin
      if (wr_en && (cmd_i.wr_slot == wmf_pkg::SLOT_W'(g))) mem[cmd_i.wr_col] <= cmd_i.pix;
      if (rd_en) rd_data <= mem[rd_col];
    end
    assign rd_bus[g] = rd_data;
  end

  always_comb begin
    for (int e = 0; e < int'(wmf_pkg::WIN_N); e++) begin
      init_mask[e] = (wmf_pkg::KW'(e / wmf_pkg::NSLOT) <= side) &&
                     (wmf_pkg::KW'(e % wmf_pkg::NSLOT) <= side);
    end
  end

  // Radix selection: one bit of the median per cycle for each channel.
  always_comb begin
    bpos = '0;
    for (int ch = 0; ch < int'(NCH); ch++) begin
      bpos       = BIT_W'(8 * ch) + BIT_W'(bit_q);
      zero_v[ch] = '0;
      one_v[ch]  = '0;
      cnt0[ch]   = '0;
      for (int e = 0; e < int'(wmf_pkg::WIN_N); e++) begin
        zero_v[ch][e] = cand_q[ch][e] & ~win_q[e][bpos];
        one_v[ch][e]  = cand_q[ch][e] &  win_q[e][bpos];
        cnt0[ch]      = cnt0[ch] + RK_W'(zero_v[ch][e]);
      end
      pick_one[ch] = !(rank_q[ch] < cnt0[ch]);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (pop_o && cmd_i.has_em) state_d = B_GATHER;
      end
      B_GATHER: begin
        if (k_q == side + wmf_pkg::KW'(1)) state_d = B_SELECT;
      end
      B_SELECT: begin
        if (bit_q == 3'd0) state_d = B_DONE;
      end
      B_DONE: begin
        if (load_out) state_d = B_IDLE;
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      k_q         <= '0;
      cap_vld_q   <= 1'b0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cap_vld_q <= rd_en;
      if (state_q == B_GATHER) begin
        k_q <= k_q + wmf_pkg::KW'(1);
      end else begin
        k_q <= '0;
      end
      if (state_q == B_SELECT) begin
        bit_q <= bit_q - 3'd1;
      end else begin
        bit_q <= 3'd7;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pos_q  <= cmd_i.em_pos;
      last_q <= cmd_i.last;
      done_q <= cmd_i.done;
      for (int i = 0; i < int'(wmf_pkg::NSLOT); i++) begin
        rslot_q[i] <= row_slot(cmd_i.em_pos, i, cfg_i);
      end
    end
    cap_idx_q <= k_q[wmf_pkg::SLOT_W-1:0];
    if (cap_vld_q) begin
      for (int i = 0; i < int'(wmf_pkg::NSLOT); i++) begin
        win_q[i * wmf_pkg::NSLOT + int'(cap_idx_q)] <= rd_bus[rslot_q[i]];
      end
    end
    if (state_q == B_GATHER) begin
      for (int ch = 0; ch < int'(NCH); ch++) begin
        cand_q[ch] <= init_mask;
        rank_q[ch] <= med_rank(cfg_i.radius);
      end
    end else if (state_q == B_SELECT) begin
      for (int ch = 0; ch < int'(NCH); ch++) begin
        med_q[ch][bit_q] <= pick_one[ch];
        if (pick_one[ch]) begin
          cand_q[ch] <= one_v[ch];
          rank_q[ch] <= rank_q[ch] - cnt0[ch];
        end else begin
          cand_q[ch] <= zero_v[ch];
        end
      end
    end
    if (load_out) begin
      out_q.med_a       <= med_q[0];
      out_q.med_b       <= cfg_i.color ? med_q[1] : 8'd0;
      out_q.med_c       <= cfg_i.color ? med_q[2] : 8'd0;
      out_q.last_in_run <= last_q;
      out_q.frame_done  <= done_q;
    end
  end

endmodule

// ===== rtl/window_median_filter.sv =====
// Channel    Direction  Transaction
// in         input      one pixel or one drain tick (valid/ready)
// out        output     one median pixel with run and frame flags (valid/ready)
// apb        input      configuration register write or read
//
// The front takes one transaction per cycle while its command queue has room
// and it is not issuing the up to radius further outputs of a row-end pixel.
// In the back a pixel without output is only taken from the queue; each output
// goes through these steps: taking the command, 2*radius+1 column reads of the
// seven line banks plus a capture of the last read, eight radix selection steps
// and loading the result.
// Reset clears all counters and control state; the line store is not cleared.
// A waiting result does not stop the back from starting on the next command.
`include "window_median_filter_macros.svh"

module window_median_filter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  wmf_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output wmf_pkg::out_item_t out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Raw register values as written over the configuration port.
  logic [wmf_pkg::RAD_W-1:0]  radius_q;
  logic [wmf_pkg::WREG_W-1:0] width_q;
  logic [wmf_pkg::HREG_W-1:0] height_q;
  logic                       color_q;
  wmf_pkg::cfg_t              cfg;
  wmf_pkg::reg_e              reg_idx;
  logic                       cfg_wr;

  logic          q_push, q_pop, q_full, q_empty, front_busy;
  wmf_pkg::cmd_t q_in, q_out;

  assign pready  = 1'b1;
  assign reg_idx = wmf_pkg::reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= wmf_pkg::RAD_W'(1);
      width_q  <= wmf_pkg::WREG_W'(640);
      height_q <= wmf_pkg::HREG_W'(480);
      color_q  <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        wmf_pkg::REG_RADIUS: radius_q <= pwdata[wmf_pkg::RAD_W-1:0];
        wmf_pkg::REG_WIDTH:  width_q  <= pwdata[wmf_pkg::WREG_W-1:0];
        wmf_pkg::REG_HEIGHT: height_q <= pwdata[wmf_pkg::HREG_W-1:0];
        wmf_pkg::REG_COLOR:  color_q  <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      wmf_pkg::REG_RADIUS: prdata = 32'(radius_q);
      wmf_pkg::REG_WIDTH:  prdata = 32'(width_q);
      wmf_pkg::REG_HEIGHT: prdata = 32'(height_q);
      wmf_pkg::REG_COLOR:  prdata = 32'(color_q);
      default:             prdata = '0;
    endcase
  end

  // Out-of-range settings are folded into range here, so the datapath only
  // ever sees a radius up to the maximum, a width of one to the line length
  // and a height of one to the frame limit.
  always_comb begin
    if (int'(radius_q) > int'(wmf_pkg::MAX_RADIUS)) begin
      cfg.radius = wmf_pkg::RAD_W'(wmf_pkg::MAX_RADIUS);
    end else begin
      cfg.radius = radius_q;
    end
    if (width_q == '0) begin
      cfg.width = wmf_pkg::EW_W'(1);
    end else if (int'(width_q) > int'(wmf_pkg::MAX_WIDTH)) begin
      cfg.width = wmf_pkg::EW_W'(wmf_pkg::MAX_WIDTH);
    end else begin
      cfg.width = wmf_pkg::EW_W'(width_q);
    end
    if (height_q == '0) begin
      cfg.height = wmf_pkg::ROW_W'(1);
    end else if (int'(height_q) > int'(wmf_pkg::MAX_HEIGHT)) begin
      cfg.height = wmf_pkg::ROW_W'(wmf_pkg::MAX_HEIGHT);
    end else begin
      cfg.height = wmf_pkg::ROW_W'(height_q);
    end
    cfg.color = color_q;
  end

  // The front tracks input and output positions and turns each pixel, and each
  // drain tick that still has an output to release, into commands; it never touches pixel storage itself.
  wmf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (q_push),
    .cmd_o      (q_in),
    .full_i     (q_full),
    .busy_o     (front_busy)
  );

  // Commands keep their order, so line store writes and window reads happen
  // in exactly the order the stream defines.
  wmf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_in),
    .pop_i   (q_pop),
    .cmd_o   (q_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // The back owns the line banks, gathers each window and selects medians.
  wmf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .empty_i     (q_empty),
    .cmd_i       (q_out),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `WMF_ASSERT_NEVER(a_queue_overflow, q_push && q_full)
  `WMF_ASSERT_NEVER(a_queue_underflow, q_pop && q_empty)
  `WMF_ASSERT_IMP(a_frame_end_is_last, out_valid_o && out_data_o.frame_done, out_data_o.last_in_run)
  `WMF_ASSERT_IMP(a_busy_holds_input, front_busy, !in_ready_o)

endmodule

// ===== dv/window_median_filter_checker.sv =====
// Watches the pixel, result and register channels of the median filter,
// keeps its own copy of the line store and counters, and checks every result.
module window_median_filter_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  wmf_pkg::in_item_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  wmf_pkg::out_item_t out_data_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic               pready_i,
  input  logic [3:0]         paddr_i,
  input  logic [31:0]        pwdata_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o
);
  import wmf_pkg::*;

  logic [PIX_W-1:0] line_mem [NSLOT*MAX_WIDTH];
  out_item_t        median_q [$];
  int               in_col, in_row, out_col, out_row;
  logic [1:0]       radius_reg;
  logic [10:0]      width_reg;
  logic [12:0]      height_reg;
  logic             color_reg;

  initial begin
    for (int i = 0; i < NSLOT*MAX_WIDTH; i++) line_mem[i] = '0;
  end

  function automatic int clampi(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // Value of middle rank among n window samples of one channel.
  function automatic logic [7:0] mid_rank(logic [PIX_W-1:0] win [WIN_N], int n, int sh);
    logic [7:0] vals [WIN_N];
    logic [7:0] v;
    int j;
    for (int i = 0; i < n; i++) begin
      v = 8'(win[i] >> sh);
      j = i;
      while (j > 0 && vals[j-1] > v) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = v;
    end
    return vals[n/2];
  endfunction

  // Median of the window around the next output position; advances it.
  function automatic out_item_t window_median(int r, int w, int h);
    logic [PIX_W-1:0] win [WIN_N];
    out_item_t o;
    int n, rr, cc;
    n = 0;
    for (int dy = -r; dy <= r; dy++) begin
      rr = clampi(out_row + dy, h - 1);
      for (int dx = -r; dx <= r; dx++) begin
        cc = clampi(out_col + dx, w - 1);
        win[n] = line_mem[(rr % NSLOT) * MAX_WIDTH + cc];
        n++;
      end
    end
    o = '0;
    o.med_a = mid_rank(win, n, 0);
    if (color_reg) begin
      o.med_b = mid_rank(win, n, 8);
      o.med_c = mid_rank(win, n, 16);
    end
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    o.frame_done = (out_row >= h);
    return o;
  endfunction

  task automatic predict(in_item_t it);
    out_item_t res [4];
    int r, w, h, cnt, need;
    r = int'(radius_reg);
    w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
    cnt = 0;
    if (it.operation == OP_PIXEL) begin
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      // A pixel after a complete frame opens a new frame.
      if (in_row >= h) begin
        in_row = 0;
        in_col = 0;
        out_row = 0;
        out_col = 0;
      end
      line_mem[(in_row % NSLOT) * MAX_WIDTH + in_col] = {it.chan_c, it.chan_b, it.chan_a};
      if (in_row >= r) begin
        while (cnt < r + 1 && out_row == in_row - r) begin
          need = out_col + r;
          if (need > w - 1) need = w - 1;
          if (need > in_col) break;
          res[cnt] = window_median(r, w, h);
          cnt++;
        end
      end
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
    end else if (in_row >= h && out_row < h) begin
      res[0] = window_median(r, w, h);
      cnt = 1;
    end
    for (int k = 0; k < cnt; k++) begin
      res[k].last_in_run = (k == cnt - 1);
      median_q.push_back(res[k]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_item;
    if (!rst_ni) begin
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      radius_reg = 2'd1;
      width_reg = 11'd640;
      height_reg = 13'd480;
      color_reg = 1'b0;
      fail_count_o = 0;
      checked_o = 0;
      pending_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_e'(paddr_i[3:2]))
          REG_RADIUS: radius_reg = pwdata_i[1:0];
          REG_WIDTH:  width_reg  = pwdata_i[10:0];
          REG_HEIGHT: height_reg = pwdata_i[12:0];
          REG_COLOR:  color_reg  = pwdata_i[0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        checked_o++;
        if (median_q.size() == 0) begin
          $error("unexpected result transaction: %p", out_data_i);
          fail_count_o++;
        end else begin
          exp_item = median_q.pop_front();
          if (out_data_i.med_a !== exp_item.med_a) begin
            $error("med_a expected %0d actual %0d", exp_item.med_a, out_data_i.med_a);
            fail_count_o++;
          end
          if (out_data_i.med_b !== exp_item.med_b) begin
            $error("med_b expected %0d actual %0d", exp_item.med_b, out_data_i.med_b);
            fail_count_o++;
          end
          if (out_data_i.med_c !== exp_item.med_c) begin
            $error("med_c expected %0d actual %0d", exp_item.med_c, out_data_i.med_c);
            fail_count_o++;
          end
          if (out_data_i.last_in_run !== exp_item.last_in_run) begin
            $error("last_in_run expected %0d actual %0d",
                   exp_item.last_in_run, out_data_i.last_in_run);
            fail_count_o++;
          end
          if (out_data_i.frame_done !== exp_item.frame_done) begin
            $error("frame_done expected %0d actual %0d",
                   exp_item.frame_done, out_data_i.frame_done);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) predict(in_data_i);
      pending_o = median_q.size();
    end
  end

endmodule

// ===== dv/window_median_filter_tb.sv =====
// Top of the median filter bench. It makes the clock, reset, register writes
// and pixel/drain transactions, and delivers the verdict. All prediction and
// comparison lives in the checker instance next to the block.
module window_median_filter_tb;
  import wmf_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count, pending, checked;
  int sent_items, reg_writes, frames_run;
  // Percentage of transactions the sender precedes with idle cycles, and of cycles in which the receiver stalls.
  int tx_idle_pct, rx_stall_pct;
  // Mirror of the programmed registers, used only to size frames.
  int cur_r, cur_w, cur_h, cur_c;

  window_median_filter u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  window_median_filter_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // The receiver stalls at random according to the current phase.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #(8 * 1500000);
    $display("RESULT: ERROR");
    $finish;
  end

  // One register write: a setup phase, then the access phase that commits it,
  // then an idle phase on the port.
  task automatic reg_write(reg_e idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    reg_writes++;
  endtask

  // Stop offering input, wait until every predicted result is out, then let
  // the back pipeline settle so that a pixel without output cannot still be
  // in flight.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic configure(int r, int w, int h, int c);
    settle();
    reg_write(REG_RADIUS, 32'(r));
    reg_write(REG_WIDTH, 32'(w));
    reg_write(REG_HEIGHT, 32'(h));
    reg_write(REG_COLOR, 32'(c));
    cur_r = r;
    cur_w = (w == 0) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
    cur_h = (h == 0) ? 1 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
    cur_c = c;
  endtask

  // Offer one transaction and hold it until the block takes it.
  task automatic send(op_e op, logic [7:0] a, logic [7:0] b, logic [7:0] c);
    int gap;
    gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{operation: op, chan_a: a, chan_b: b, chan_c: c};
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    sent_items++;
  endtask

  task automatic send_pixel();
    send(OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic send_drain();
    send(OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin tx_idle_pct = 51; rx_stall_pct = 0;  end
      2: begin tx_idle_pct = 0;  rx_stall_pct = 51; end
      default: begin tx_idle_pct = 19; rx_stall_pct = 19; end
    endcase
  endtask

  // One frame with random content. Most frames are complete and fully
  // drained; some are cut short, overrun, drained early or left undrained.
  task automatic random_frame();
    int npix, ndrain, early_at;
    npix   = cur_w * cur_h;
    ndrain = cur_r * cur_w + $urandom_range(0, 2);
    case ($urandom_range(9))
      0: npix = $urandom_range(1, npix);
      1: npix = npix + $urandom_range(1, cur_w);
      2: ndrain = 0;
      default: ;
    endcase
    // A frame near the height limit is only started, never filled.
    if (npix > 64) npix = $urandom_range(1, 64);
    if (cur_r >= cur_h) ndrain = cur_w * cur_h + 1;
    early_at = ($urandom_range(4) == 0) ? $urandom_range(0, npix - 1) : -1;
    for (int i = 0; i < npix; i++) begin
      if (i == early_at) send_drain();
      send_pixel();
    end
    for (int i = 0; i < ndrain; i++) send_drain();
    frames_run++;
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    sent_items  = 0;
    reg_writes  = 0;
    frames_run  = 0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Opening frame: 8 columns by 7 rows fills every line slot over the
    // columns that later small frames use, so no window ever touches a
    // line store entry that was never written. Extreme values first.
    configure(1, 8, 7, 1);
    send(OP_PIXEL, 8'h00, 8'hff, 8'h00);
    send(OP_PIXEL, 8'hff, 8'h00, 8'hff);
    send(OP_PIXEL, 8'hff, 8'hff, 8'hff);
    send(OP_DRAIN, 8'h00, 8'h00, 8'h00);  // drain before the frame is complete
    for (int i = 3; i < 56; i++) send_pixel();
    for (int i = 0; i < 10; i++) send_drain();  // the last two come too late

    // Height register above range acts as the largest height; cut the frame
    // down to four rows once four rows are in, then drain it.
    set_idling(1);
    configure(3, 5, 8191, 1);
    for (int i = 0; i < 20; i++) send_pixel();
    configure(3, 5, 4, 1);
    for (int i = 0; i < 16; i++) send_drain();

    // Width above range acts as the full line length: the first part of one
    // such row, each pixel releasing its own output. The next settings wrap
    // the row and so close the frame.
    set_idling(2);
    configure(0, 2047, 1, 1);
    for (int i = 0; i < 48; i++) send_pixel();

    // Zero width and height act as one: each pixel is a frame of its own.
    set_idling(3);
    configure(0, 0, 0, 0);
    send(OP_PIXEL, 8'hff, 8'h00, 8'h00);
    send(OP_PIXEL, 8'h00, 8'hff, 8'hff);
    send(OP_DRAIN, 8'h00, 8'h00, 8'h00);
    send(OP_PIXEL, 8'h5a, 8'ha5, 8'h3c);

    // Radius at least the height: every output comes from drain transactions.
    set_idling(2);
    configure(3, 3, 3, 0);
    random_frame();

    // Random part, phase by phase through the idling patterns.
    for (int ph = 0; sent_items < 230; ph++) begin
      set_idling(ph);
      if ($urandom_range(2) == 0 || ph == 0) begin
        configure($urandom_range(0, 3),
                  ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 8),
                  ($urandom_range(29) == 0) ? 8191 : $urandom_range(0, 6),
                  $urandom_range(0, 1));
      end
      random_frame();
      // In some phases the sender holds back until every result of the frame has arrived.
      if ($urandom_range(4) == 0 || ph == 3) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
    end

    in_valid_i <= 1'b0;
    set_idling(0);
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("Sent %0d pixel and drain transactions in %0d random frames, %0d register writes.",
             sent_items, frames_run, reg_writes);
    $display("Checked %0d median results across gray and color modes, radius 0 to 3.",
             checked);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/wmf_pkg.sv
rtl/wmf_queue.sv
rtl/wmf_front.sv
rtl/wmf_back.sv
rtl/window_median_filter.sv
dv/window_median_filter_checker.sv
dv/window_median_filter_tb.sv
